### sv/vpma_pkg.sv
package vpma_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_DEPTH   = 64;
  localparam int MAX_POOL    = 4;
  localparam int ACC_ENTRIES = 16384;
  localparam int MAX_HEIGHT  = 4095;

  localparam int ACC_W   = 22;
  localparam int IDX_W   = 14;
  localparam int CNT_W   = 7;
  localparam int CFG_W   = 12;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd6;

  localparam logic MODE_AVG = 1'b0;
  localparam logic MODE_MAX = 1'b1;

  // Clamped geometry seen by the front end.
  typedef struct packed {
    logic [8:0]  w;
    logic [11:0] h;
    logic [6:0]  d;
    logic [2:0]  px;
    logic [2:0]  py;
    logic [2:0]  pz;
  } geom_t;

  // One classified sample on its way to the back end.
  typedef struct packed {
    logic signed [15:0] sample;
    logic [IDX_W-1:0]   idx;
    logic               first;
    logic               last;
    logic               done;
    logic [7:0]         ox;
    logic [11:0]        oy;
    logic [5:0]         oz;
    logic [CNT_W-1:0]   cnt;
  } item_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### sv/vpma_if.sv
interface vpma_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface vpma_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pooled;
  logic [7:0]         out_col;
  logic [11:0]        out_row;
  logic [5:0]         out_slice;
  logic               volume_done;
  modport source (output valid, output pooled, output out_col, output out_row,
                  output out_slice, output volume_done, input ready);
  modport sink (input valid, input pooled, input out_col, input out_row,
                input out_slice, input volume_done, output ready);
endinterface

### sv/vpma_front.sv
module vpma_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 restart,
  input  vpma_pkg::geom_t      geom,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [15:0]   in_sample,
  input  logic                 q_full,
  output logic                 q_push,
  output vpma_pkg::item_t      q_item
);

  logic [7:0]  c;
  logic [11:0] r;
  logic [5:0]  z;
  logic [1:0]  cx, cy, cz;
  logic [7:0]  ox;
  logic [11:0] oy;
  logic [5:0]  oz;

  logic end_z, end_c, end_r;
  logic win_z, win_c, win_r;
  logic [2:0] nx, ny, nz;
  logic [5:0] cnt_xy;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  assign end_z = ({1'b0, z} + 7'd1) == geom.d;
  assign end_c = ({1'b0, c} + 9'd1) == geom.w;
  assign end_r = (r + 12'd1) == geom.h;
  assign nz = {1'b0, cz} + 3'd1;
  assign nx = {1'b0, cx} + 3'd1;
  assign ny = {1'b0, cy} + 3'd1;
  assign win_z = (nz == geom.pz) || end_z;
  assign win_c = (nx == geom.px) || end_c;
  assign win_r = (ny == geom.py) || end_r;

  // At the last element of a window the sub-positions give its true extent.
  assign cnt_xy = {3'b000, nx} * {3'b000, ny};

  always_comb begin
    q_item.sample = in_sample;
    q_item.idx    = {ox, oz};
    q_item.first  = (cx == 2'd0) && (cy == 2'd0) && (cz == 2'd0);
    q_item.last   = win_z && win_c && win_r;
    q_item.done   = end_z && end_c && end_r;
    q_item.ox     = ox;
    q_item.oy     = oy;
    q_item.oz     = oz;
    q_item.cnt    = {1'b0, cnt_xy} * {4'b0000, nz};
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      c <= '0; r <= '0; z <= '0;
      cx <= '0; cy <= '0; cz <= '0;
      ox <= '0; oy <= '0; oz <= '0;
    end else if (q_push) begin
      if (end_z) begin
        z <= '0; cz <= '0; oz <= '0;
        if (end_c) begin
          c <= '0; cx <= '0; ox <= '0;
          if (end_r) begin
            r <= '0; cy <= '0; oy <= '0;
          end else begin
            r <= r + 12'd1;
            if (ny == geom.py) begin
              cy <= '0;
              oy <= oy + 12'd1;
            end else begin
              cy <= ny[1:0];
            end
          end
        end else begin
          c <= c + 8'd1;
          if (nx == geom.px) begin
            cx <= '0;
            ox <= ox + 8'd1;
          end else begin
            cx <= nx[1:0];
          end
        end
      end else begin
        z <= z + 6'd1;
        if (nz == geom.pz) begin
          cz <= '0;
          oz <= oz + 6'd1;
        end else begin
          cz <= nz[1:0];
        end
      end
    end
  end

endmodule

### sv/vpma_fifo.sv
module vpma_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  vpma_pkg::item_t wr_item,
  input  logic            pop,
  output vpma_pkg::item_t rd_item,
  output logic            full,
  output logic            empty
);

  vpma_pkg::item_t slots [4];
  logic [1:0] wptr, rptr;
  logic [2:0] count;

  assign full    = count == 3'd4;
  assign empty   = count == 3'd0;
  assign rd_item = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0; rptr <= '0; count <= '0;
    end else begin
      if (push) wptr <= wptr + 2'd1;
      if (pop) rptr <= rptr + 2'd1;
      case ({push, pop})
        2'b10:   count <= count + 3'd1;
        2'b01:   count <= count - 3'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/vpma_back.sv
module vpma_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            mode,
  input  logic            q_empty,
  input  vpma_pkg::item_t q_item,
  output logic            q_pop,
  vpma_out_if.source      res
);

  typedef enum logic [2:0] {S_IDLE, S_UPD, S_DIV, S_EMIT} state_t;

  state_t state;
  vpma_pkg::item_t cur;
  logic signed [vpma_pkg::ACC_W-1:0] acc_mem [vpma_pkg::ACC_ENTRIES];
  logic signed [vpma_pkg::ACC_W-1:0] rd_data;
  logic signed [vpma_pkg::ACC_W-1:0] upd;
  logic signed [vpma_pkg::ACC_W-1:0] s_ext;
  logic signed [15:0] result;

  logic [vpma_pkg::ACC_W-1:0] quot;
  logic [7:0]  rem;
  logic [8:0]  rem_sh;
  logic [4:0]  step;
  logic        neg;

  assign q_pop = (state == S_IDLE) && !q_empty;
  assign s_ext = vpma_pkg::ACC_W'(cur.sample);

  always_comb begin
    if (cur.first) begin
      upd = s_ext;
    end else if (mode == vpma_pkg::MODE_MAX) begin
      upd = (s_ext > rd_data) ? s_ext : rd_data;
    end else begin
      upd = rd_data + s_ext;
    end
  end

  // Restoring division on the magnitude, one quotient bit per cycle.
  assign rem_sh = {rem, quot[vpma_pkg::ACC_W-1]};

  always_ff @(posedge clk) begin
    rd_data <= acc_mem[q_item.idx];
    if (state == S_UPD) begin
      acc_mem[cur.idx] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res.valid <= 1'b0;
    end else begin
      if (res.valid && res.ready && state != S_EMIT) res.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur   <= q_item;
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (!cur.last) begin
            state <= S_IDLE;
          end else if (mode == vpma_pkg::MODE_MAX) begin
            result <= upd[15:0];
            state  <= S_EMIT;
          end else begin
            neg   <= upd[vpma_pkg::ACC_W-1];
            quot  <= upd[vpma_pkg::ACC_W-1] ? -upd : upd;
            rem   <= '0;
            step  <= 5'(vpma_pkg::ACC_W - 1);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_sh >= {2'b00, cur.cnt}) begin
            rem  <= 8'(rem_sh - {2'b00, cur.cnt});
            quot <= {quot[vpma_pkg::ACC_W-2:0], 1'b1};
          end else begin
            rem  <= rem_sh[7:0];
            quot <= {quot[vpma_pkg::ACC_W-2:0], 1'b0};
          end
          if (step == 5'd0) begin
            state <= S_EMIT;
          end else begin
            step <= step - 5'd1;
          end
          if (step == 5'd0) begin
            if (rem_sh >= {2'b00, cur.cnt}) begin
              result <= neg ? -{quot[14:0], 1'b1} : {quot[14:0], 1'b1};
            end else begin
              result <= neg ? -{quot[14:0], 1'b0} : {quot[14:0], 1'b0};
            end
          end
        end
        S_EMIT: begin
          // A transfer in this cycle frees the output register for the next result.
          if (!res.valid || res.ready) begin
            res.valid       <= 1'b1;
            res.pooled      <= result;
            res.out_col     <= cur.ox;
            res.out_row     <= cur.oy;
            res.out_slice   <= cur.oz;
            res.volume_done <= cur.done;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/volume_pool_max_avg.sv
// Streams a volume one Q8.8 sample per transfer (depth fastest, then column,
// then row) and emits one max or average per non-overlapping window when its
// last element arrives. The front end takes a sample every cycle into a
// four-deep queue while the queue has room; the back end pops one sample at
// a time and does a read-modify-write of the window accumulator memory, a max
// result then loads the output register, and an average result first runs a
// bit-serial division; the back end takes no new sample until it is through
// with the last one, nor while the result receiver holds off. Any write to
// configuration registers 0 to 6 restarts the volume at its first position.
module volume_pool_max_avg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [vpma_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vpma_pkg::CFG_W-1:0]         cfg_data,
  vpma_in_if.sink                            sample_ch,
  vpma_out_if.source                         result_ch
);

  logic [8:0]  vol_width;
  logic [11:0] vol_height;
  logic [6:0]  vol_depth;
  logic [2:0]  pool_x, pool_y, pool_z;
  logic        pool_mode;
  logic        restart;

  vpma_pkg::geom_t geom;
  vpma_pkg::item_t push_item, head_item;
  vpma_pkg::q_stat_t qs;

  assign restart = cfg_we && (cfg_index <= vpma_pkg::REG_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      vol_width  <= 9'd1;
      vol_height <= 12'd1;
      vol_depth  <= 7'd1;
      pool_x     <= 3'd2;
      pool_y     <= 3'd2;
      pool_z     <= 3'd1;
      pool_mode  <= vpma_pkg::MODE_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        vpma_pkg::REG_WIDTH:  vol_width  <= cfg_data[8:0];
        vpma_pkg::REG_HEIGHT: vol_height <= cfg_data;
        vpma_pkg::REG_DEPTH:  vol_depth  <= cfg_data[6:0];
        vpma_pkg::REG_POOL_X: pool_x     <= cfg_data[2:0];
        vpma_pkg::REG_POOL_Y: pool_y     <= cfg_data[2:0];
        vpma_pkg::REG_POOL_Z: pool_z     <= cfg_data[2:0];
        vpma_pkg::REG_MODE:   pool_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    geom.w  = (vol_width == '0) ? 9'd1 :
              (vol_width > 9'(vpma_pkg::MAX_WIDTH)) ? 9'(vpma_pkg::MAX_WIDTH) : vol_width;
    geom.h  = (vol_height == '0) ? 12'd1 : vol_height;
    geom.d  = (vol_depth == '0) ? 7'd1 :
              (vol_depth > 7'(vpma_pkg::MAX_DEPTH)) ? 7'(vpma_pkg::MAX_DEPTH) : vol_depth;
    geom.px = (pool_x == '0) ? 3'd1 :
              (pool_x > 3'(vpma_pkg::MAX_POOL)) ? 3'(vpma_pkg::MAX_POOL) : pool_x;
    geom.py = (pool_y == '0) ? 3'd1 :
              (pool_y > 3'(vpma_pkg::MAX_POOL)) ? 3'(vpma_pkg::MAX_POOL) : pool_y;
    geom.pz = (pool_z == '0) ? 3'd1 :
              (pool_z > 3'(vpma_pkg::MAX_POOL)) ? 3'(vpma_pkg::MAX_POOL) : pool_z;
  end

  vpma_front u_front (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .geom      (geom),
    .in_valid  (sample_ch.valid),
    .in_ready  (sample_ch.ready),
    .in_sample (sample_ch.sample),
    .q_full    (qs.full),
    .q_push    (qs.push),
    .q_item    (push_item)
  );

  vpma_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (qs.push),
    .wr_item (push_item),
    .pop     (qs.pop),
    .rd_item (head_item),
    .full    (qs.full),
    .empty   (qs.empty)
  );

  vpma_back u_back (
    .clk     (clk),
    .rst     (rst),
    .mode    (pool_mode),
    .q_empty (qs.empty),
    .q_item  (head_item),
    .q_pop   (qs.pop),
    .res     (result_ch)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) qs.push |-> !qs.full)
    else $error("sample queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) qs.pop |-> !qs.empty)
    else $error("sample queue read while empty");
  a_held_result: assert property (@(posedge clk) disable iff (rst)
      (result_ch.valid && !result_ch.ready) |=> result_ch.valid)
    else $error("pending result dropped");
`endif

endmodule

### sim/tb_volume_pool_max_avg.sv
`timescale 1ns / 100ps

module tb_volume_pool_max_avg;

  typedef struct {
    logic signed [15:0] pooled;
    logic [7:0]         col;
    logic [11:0]        row;
    logic [5:0]         slice;
    logic               done;
  } window_result_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [vpma_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [vpma_pkg::CFG_W-1:0]     cfg_data;

  vpma_in_if  sample_ch ();
  vpma_out_if result_ch ();

  volume_pool_max_avg dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample_ch (sample_ch),
    .result_ch (result_ch)
  );

  // Predictor state: register copies, window store and stream position.
  int unsigned vol_w, vol_h, vol_d, win_x, win_y, win_z;
  logic        mode_reg;
  int          window_store [vpma_pkg::ACC_ENTRIES];
  int unsigned col_at, row_at, slice_at;

  logic signed [15:0] samples_to_send [$];
  window_result_t     expected_windows [$];
  int unsigned        samples_taken;
  int unsigned        error_count;
  bit                 taken_last_edge;
  int unsigned        send_idle_pct, recv_idle_pct;
  int unsigned        hold_left;
  bit                 hold_used;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned window_span(int unsigned start, int unsigned size,
                                              int unsigned total);
    return (total - start < size) ? total - start : size;
  endfunction

  function automatic void apply_register(logic [vpma_pkg::CFG_IDX_W-1:0] index,
                                         int unsigned value);
    case (index)
      vpma_pkg::REG_WIDTH: begin
        vol_w = value & 'h1FF;
      end
      vpma_pkg::REG_HEIGHT: begin
        vol_h = value & 'hFFF;
      end
      vpma_pkg::REG_DEPTH: begin
        vol_d = value & 'h7F;
      end
      vpma_pkg::REG_POOL_X: begin
        win_x = value & 7;
      end
      vpma_pkg::REG_POOL_Y: begin
        win_y = value & 7;
      end
      vpma_pkg::REG_POOL_Z: begin
        win_z = value & 7;
      end
      vpma_pkg::REG_MODE: begin
        mode_reg = value[0];
      end
      default: begin
      end
    endcase
    col_at = 0;
    row_at = 0;
    slice_at = 0;
  endfunction

  // Folds one sample into its window and queues the window result when the
  // sample closes the window.
  function automatic void pool_sample(logic signed [15:0] s);
    int unsigned w, h, d, px, py, pz, c, r, z, ox, oy, oz, idx, cnt;
    bit first, last, done;
    int v;
    window_result_t res;
    w = clip(vol_w, 1, vpma_pkg::MAX_WIDTH);
    h = clip(vol_h, 1, vpma_pkg::MAX_HEIGHT);
    d = clip(vol_d, 1, vpma_pkg::MAX_DEPTH);
    px = clip(win_x, 1, vpma_pkg::MAX_POOL);
    py = clip(win_y, 1, vpma_pkg::MAX_POOL);
    pz = clip(win_z, 1, vpma_pkg::MAX_POOL);
    c = col_at;
    r = row_at;
    z = slice_at;
    done = 1'b0;
    if (c >= w || r >= h || z >= d) begin
      c = 0;
      r = 0;
      z = 0;
    end
    ox = c / px;
    oy = r / py;
    oz = z / pz;
    idx = (ox * vpma_pkg::MAX_DEPTH + oz) % vpma_pkg::ACC_ENTRIES;
    first = (c % px == 0) && (r % py == 0) && (z % pz == 0);
    if (first) begin
      window_store[idx] = int'(s);
    end else if (mode_reg == vpma_pkg::MODE_MAX) begin
      if (int'(s) > window_store[idx]) window_store[idx] = int'(s);
    end else begin
      window_store[idx] += int'(s);
    end
    last = ((z + 1) % pz == 0 || z + 1 == d) && ((c + 1) % px == 0 || c + 1 == w) &&
           ((r + 1) % py == 0 || r + 1 == h);
    z++;
    if (z == d) begin
      z = 0;
      c++;
      if (c == w) begin
        c = 0;
        r++;
        if (r == h) begin
          r = 0;
          done = 1'b1;
        end
      end
    end
    col_at = c;
    row_at = r;
    slice_at = z;
    if (last) begin
      v = window_store[idx];
      if (mode_reg == vpma_pkg::MODE_AVG) begin
        cnt = window_span(ox * px, px, w) * window_span(oy * py, py, h) *
              window_span(oz * pz, pz, d);
        v = v / int'(cnt);
      end
      res.pooled = v[15:0];
      res.col = ox[7:0];
      res.row = oy[11:0];
      res.slice = oz[5:0];
      res.done = done;
      expected_windows.push_back(res);
    end
  endfunction

  task automatic report_mismatch(string what);
    error_count++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  // Input side: acceptance is seen at the rising edge, new data goes out at
  // the falling edge.
  always @(posedge clk) begin
    if (!rst && sample_ch.valid && sample_ch.ready) begin
      pool_sample(samples_to_send.pop_front());
      samples_taken++;
      taken_last_edge = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else if (!(sample_ch.valid && !taken_last_edge)) begin
      if (samples_to_send.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        sample_ch.valid <= 1'b1;
        sample_ch.sample <= samples_to_send[0];
      end else begin
        sample_ch.valid <= 1'b0;
      end
    end
    taken_last_edge = 1'b0;
    if (samples_taken < 420) begin
      send_idle_pct = 38;
      recv_idle_pct = 65;
    end else if (samples_taken < 840) begin
      send_idle_pct = 65;
      recv_idle_pct = 38;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  // Output side, with one long hold-off so the block backs up into its input.
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (!hold_used && samples_taken >= 300) begin
        hold_used = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    window_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_windows.size() == 0) begin
        report_mismatch($sformatf("unexpected window result pooled=%0d col=%0d row=%0d",
                                  result_ch.pooled, result_ch.out_col, result_ch.out_row));
      end else begin
        want = expected_windows.pop_front();
        if (result_ch.pooled !== want.pooled)
          report_mismatch($sformatf("pooled %0d, want %0d", result_ch.pooled, want.pooled));
        if (result_ch.out_col !== want.col)
          report_mismatch($sformatf("out_col %0d, want %0d", result_ch.out_col, want.col));
        if (result_ch.out_row !== want.row)
          report_mismatch($sformatf("out_row %0d, want %0d", result_ch.out_row, want.row));
        if (result_ch.out_slice !== want.slice)
          report_mismatch($sformatf("out_slice %0d, want %0d", result_ch.out_slice,
                                    want.slice));
        if (result_ch.volume_done !== want.done)
          report_mismatch($sformatf("volume_done %0b, want %0b", result_ch.volume_done,
                                    want.done));
      end
    end
  end

  task automatic write_reg(logic [vpma_pkg::CFG_IDX_W-1:0] index, int unsigned value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value[vpma_pkg::CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    apply_register(index, value);
  endtask

  // Register writes are only safe once the block has drained, including
  // samples that close no window and so leave nothing to wait for.
  task automatic wait_drained();
    while (samples_to_send.size() > 0 || expected_windows.size() > 0 || sample_ch.valid)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 11))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_geometry(int unsigned w, int unsigned h, int unsigned d, int unsigned px,
                              int unsigned py, int unsigned pz, logic m,
                              int unsigned count);
    wait_drained();
    write_reg(vpma_pkg::REG_WIDTH, w);
    write_reg(vpma_pkg::REG_HEIGHT, h);
    write_reg(vpma_pkg::REG_DEPTH, d);
    write_reg(vpma_pkg::REG_POOL_X, px);
    write_reg(vpma_pkg::REG_POOL_Y, py);
    write_reg(vpma_pkg::REG_POOL_Z, pz);
    write_reg(vpma_pkg::REG_MODE, 32'(m));
    repeat (count) samples_to_send.push_back(pick_sample());
  endtask

  initial begin
    int unsigned w, h, d, vol, count, pushed;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = vpma_pkg::REG_WIDTH;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.sample = '0;
    result_ch.ready = 1'b0;
    error_count = 0;
    samples_taken = 0;
    taken_last_edge = 1'b0;
    hold_used = 1'b0;
    hold_left = 0;
    send_idle_pct = 38;
    recv_idle_pct = 65;
    vol_w = 1;
    vol_h = 1;
    vol_d = 1;
    win_x = 2;
    win_y = 2;
    win_z = 1;
    mode_reg = vpma_pkg::MODE_MAX;
    col_at = 0;
    row_at = 0;
    slice_at = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset geometry is a single element, so every sample is its own window.
    samples_to_send.push_back(16'sh7FFF);
    samples_to_send.push_back(16'sh8000);
    samples_to_send.push_back(16'sh0000);
    samples_to_send.push_back(16'shFFFF);
    samples_to_send.push_back(16'sh5555);
    samples_to_send.push_back(16'shAAAA);
    wait_drained();
    write_reg(vpma_pkg::REG_MODE, 32'(vpma_pkg::MODE_AVG));
    samples_to_send.push_back(16'sh8000);
    samples_to_send.push_back(16'sh7FFF);
    samples_to_send.push_back(16'sh0000);
    // Zero and over-range sizes are clamped.
    run_geometry(0, 0, 0, 0, 0, 0, vpma_pkg::MODE_MAX, 4);
    run_geometry(3, 2, 2, 7, 7, 7, vpma_pkg::MODE_AVG, 14);
    // Extremes of the geometry; the tall one and the two-row one are cut short by the next write.
    run_geometry(511, 1, 1, 4, 1, 1, vpma_pkg::MODE_AVG, 256);
    run_geometry(2, 1, 127, 1, 1, 4, vpma_pkg::MODE_MAX, 128);
    run_geometry(1, 4095, 1, 1, 4, 1, vpma_pkg::MODE_AVG, 40);
    run_geometry(256, 2, 1, 3, 2, 1, vpma_pkg::MODE_MAX, 70);
    pushed = 6 + 3 + 4 + 14 + 256 + 128 + 40 + 70;

    while (pushed < 1250) begin
      w = $urandom_range(1, 10);
      h = $urandom_range(1, 6);
      d = $urandom_range(1, 5);
      vol = w * h * d;
      count = vol * $urandom_range(1, 2) + $urandom_range(0, 3);
      if (count > 200) count = 200;
      if ($urandom_range(0, 9) == 0) count = $urandom_range(1, vol);
      run_geometry(w, h, d, $urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4),
                   1'($urandom_range(0, 1)), count);
      pushed += count;
    end

    wait_drained();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### filelist.f
sv/vpma_pkg.sv
sv/vpma_if.sv
sv/vpma_front.sv
sv/vpma_fifo.sv
sv/vpma_back.sv
sv/volume_pool_max_avg.sv
sim/tb_volume_pool_max_avg.sv
